>>> rtl/core/segment_range_map_macros.svh
// Assertion macros for the segment range map RTL.
// Used by the top level only; bodies vanish when SYNTHESIS is defined.
`ifndef SEGMENT_RANGE_MAP_MACROS_SVH
`define SEGMENT_RANGE_MAP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SRM_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define SRM_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define SRM_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define SRM_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

>>> rtl/core/srm_pkg.sv
// Package for the segment range map: beat types, codes and defaults.
// No dependencies; used by srm_acc and segment_range_map.
package srm_pkg;

    localparam int ENTRIES_DEF        = 64;
    localparam int OBJECT_ID_BITS_DEF = 16;
    localparam int OBJ_FIELD_W        = 16;

    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_MAIN  = 2'd0;
    localparam logic [1:0] KIND_DEBUG = 2'd1;
    localparam logic [1:0] KIND_TOP   = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_ADDR   = 2'd2,
        OP_NAME   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_SKIPPED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]             operation;
        logic [OBJ_FIELD_W-1:0] object_id;
        logic [1:0]             segment_kind;
        logic [31:0]            seg_start;
        logic [31:0]            seg_size;
        logic [31:0]            query_addr;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             status;
        logic                   is_gap;
        logic [31:0]            region_start;
        logic [31:0]            region_end;
        logic [OBJ_FIELD_W-1:0] found_object;
        logic [1:0]             found_kind;
    } t_out_item;

    // Scan control from the sequencer to the accumulator.
    typedef struct packed {
        logic start;   // reset accumulators for a new scan
        logic en;      // read data of one entry is present this cycle
        t_op  op;
    } t_acc_ctrl;

    // Scan outcome from the accumulator (parameter-free part).
    typedef struct packed {
        logic        overlap;
        logic        slot_ok;
        logic        sel_ok;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] sel_start;
        logic [31:0] sel_end;
        logic [1:0]  sel_kind;
    } t_acc_stat;

endpackage

>>> rtl/core/srm_mem.sv
// Segment table storage: one write port, one read port, registered read data.
// Depends on nothing; instantiated by segment_range_map.
module srm_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 83
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/srm_acc.sv
// Scan accumulator: folds one table entry per cycle into overlap, free slot,
// hit, gap bounds and best name match. Depends on srm_pkg.
module srm_acc #(
    parameter int IDX_W = 6,
    parameter int OBJ_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srm_pkg::t_acc_ctrl   i_ctrl,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic                 i_e_valid,
    input  logic [31:0]          i_e_start,
    input  logic [31:0]          i_e_end,
    input  logic [OBJ_W-1:0]     i_e_obj,
    input  logic [1:0]           i_e_kind,
    input  logic [31:0]          i_q_start,
    input  logic [31:0]          i_q_end,
    input  logic [31:0]          i_q_addr,
    input  logic [OBJ_W-1:0]     i_q_obj,
    input  logic [1:0]           i_q_kind,
    output srm_pkg::t_acc_stat   o_stat,
    output logic [IDX_W-1:0]     o_slot,
    output logic [OBJ_W-1:0]     o_sel_obj
);

    logic             r_overlap, r_slot_ok, r_sel_ok;
    logic [IDX_W-1:0] r_slot;
    logic [31:0]      r_lo, r_hi, r_sel_start, r_sel_end;
    logic [OBJ_W-1:0] r_sel_obj;
    logic [1:0]       r_sel_kind;

    logic e_ovl, e_hit, e_name, take_sel, lo_upd, hi_upd;

    always_comb begin
        e_ovl  = i_e_valid && (i_q_start < i_e_end) && (i_e_start < i_q_end);
        e_hit  = i_e_valid && (i_q_addr >= i_e_start) && (i_q_addr < i_e_end);
        e_name = i_e_valid && (i_e_obj == i_q_obj) && (i_e_kind == i_q_kind);
        lo_upd = i_e_valid && (i_e_end <= i_q_addr) && (i_e_end > r_lo);
        hi_upd = i_e_valid && (i_e_start > i_q_addr) && (i_e_start < r_hi);
        case (i_ctrl.op)
            srm_pkg::OP_ADDR: take_sel = e_hit && !r_sel_ok;
            srm_pkg::OP_NAME: take_sel = e_name && (!r_sel_ok || (i_e_start < r_sel_start));
            default:          take_sel = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.start) begin
            r_overlap <= 1'b0;
            r_slot_ok <= 1'b0;
            r_sel_ok  <= 1'b0;
            r_lo      <= '0;
            r_hi      <= srm_pkg::ADDR_ALL_ONES;
        end else if (i_ctrl.en) begin
            if (e_ovl) begin
                r_overlap <= 1'b1;
            end
            if (!i_e_valid && !r_slot_ok) begin
                r_slot_ok <= 1'b1;
            end
            if (take_sel) begin
                r_sel_ok <= 1'b1;
            end
            if (lo_upd) begin
                r_lo <= i_e_end;
            end
            if (hi_upd) begin
                r_hi <= i_e_start;
            end
        end
    end

    // Payload of the accumulator: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            if (!i_e_valid && !r_slot_ok) begin
                r_slot <= i_idx;
            end
            if (take_sel) begin
                r_sel_start <= i_e_start;
                r_sel_end   <= i_e_end;
                r_sel_obj   <= i_e_obj;
                r_sel_kind  <= i_e_kind;
            end
        end
    end

    always_comb begin
        o_stat.overlap   = r_overlap;
        o_stat.slot_ok   = r_slot_ok;
        o_stat.sel_ok    = r_sel_ok;
        o_stat.lo        = r_lo;
        o_stat.hi        = r_hi;
        o_stat.sel_start = r_sel_start;
        o_stat.sel_end   = r_sel_end;
        o_stat.sel_kind  = r_sel_kind;
    end

    assign o_slot    = r_slot;
    assign o_sel_obj = r_sel_obj;

endmodule

>>> rtl/core/segment_range_map.sv
// Segment range map: a table of up to ENTRIES loaded memory segments with
// insert, clear, lookup by address and lookup by object and kind. Each input
// beat gives exactly one output beat. All table state, valid bits included,
// sits in one single-port-read memory (srm_mem) read one entry per cycle; an
// insert or a lookup scans every entry before its result is ready for the
// output register, and an insert that is stored then writes the new entry in
// a write state of its own. A clear sweeps the valid bits, one entry per
// cycle; inserts that are skipped or whose end overflows 32 bits are answered
// without a scan and without touching the table. After reset the same sweep
// runs once, so the input side stays not ready until every entry is cleared.
// One item is worked on at a time; the input takes a new beat as soon as the
// sequencer is idle, even while the previous result still waits in the
// output register.
// Segment ends are start plus size rounded up to 16. Of several name matches
// the one with the lowest start is returned; address lookups that miss
// return the gap bounded by the nearest stored end below and start above.
// Depends on srm_pkg, srm_mem, srm_acc and segment_range_map_macros.svh.
`include "segment_range_map_macros.svh"

module segment_range_map #(
    parameter int ENTRIES        = srm_pkg::ENTRIES_DEF,
    parameter int OBJECT_ID_BITS = srm_pkg::OBJECT_ID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srm_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srm_pkg::t_out_item o_out
);

    // Only the low bits of the object id count, never more than the field.
    localparam int OBJ_W = (OBJECT_ID_BITS < srm_pkg::OBJ_FIELD_W) ?
                           OBJECT_ID_BITS : srm_pkg::OBJ_FIELD_W;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int WORD_W = 1 + 2 + OBJ_W + 32 + 32;

    // Sequencer state and counters.
    srm_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    // Held item.
    srm_pkg::t_op     r_op;
    logic [OBJ_W-1:0] r_obj;
    logic [1:0]       r_kind;
    logic [31:0]      r_start, r_end, r_addr;

    // Pending result and output register.
    srm_pkg::t_out_item r_res, n_res;
    srm_pkg::t_out_item r_out;
    logic               r_out_valid;

    // Control decoded from the state.
    logic in_acc, out_acc, out_load, res_ld;
    logic issue, scan_done, sweep_last;
    logic ins_skip, ins_ovf;
    logic [33:0] rsize, end34;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    srm_pkg::t_acc_ctrl acc_ctrl;
    srm_pkg::t_acc_stat acc_stat;
    logic [IDX_W-1:0]   acc_slot;
    logic [OBJ_W-1:0]   acc_sel_obj;

    // Unpacked read word: {valid, kind, object, end, start}.
    logic             e_valid;
    logic [1:0]       e_kind;
    logic [OBJ_W-1:0] e_obj;
    logic [31:0]      e_end, e_start;

    assign {e_valid, e_kind, e_obj, e_end, e_start} = mem_rdata;

    // Insert pre-checks straight off the input beat: skip and overflow.
    always_comb begin
        rsize    = ({2'b00, i_in.seg_size} + 34'd15) & ~34'hF;
        end34    = {2'b00, i_in.seg_start} + rsize;
        ins_skip = (i_in.segment_kind >= srm_pkg::KIND_TOP) ||
                   (i_in.seg_start == '0) || (i_in.seg_size == '0);
        ins_ovf  = |end34[33:32];
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;
    assign issue      = (r_cnt != CNT_W'(ENTRIES));
    assign scan_done  = !issue && !r_rd_vld;
    assign sweep_last = (r_cnt == CNT_W'(ENTRIES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srm_pkg::S_INIT: begin
                if (sweep_last) n_state = srm_pkg::S_IDLE;
            end
            srm_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (srm_pkg::t_op'(i_in.operation))
                        srm_pkg::OP_CLEAR:  n_state = srm_pkg::S_CLEAR;
                        srm_pkg::OP_INSERT: n_state = (ins_skip || ins_ovf) ?
                                                      srm_pkg::S_DONE : srm_pkg::S_SCAN;
                        default:            n_state = srm_pkg::S_SCAN;
                    endcase
                end
            end
            srm_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = (r_op == srm_pkg::OP_INSERT && !acc_stat.overlap &&
                               acc_stat.slot_ok) ? srm_pkg::S_WRITE : srm_pkg::S_DONE;
                end
            end
            srm_pkg::S_WRITE: n_state = srm_pkg::S_DONE;
            srm_pkg::S_CLEAR: begin
                if (sweep_last) n_state = srm_pkg::S_DONE;
            end
            srm_pkg::S_DONE: begin
                if (out_load) n_state = srm_pkg::S_IDLE;
            end
            default: n_state = srm_pkg::S_INIT;
        endcase
    end

    // Outputs of the sequencer: handshakes, memory port, scan control, result.
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        res_ld     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_cnt[IDX_W-1:0];
        mem_wdata  = '0;
        acc_ctrl.start = 1'b0;
        acc_ctrl.en    = r_rd_vld;
        acc_ctrl.op    = r_op;
        n_res      = '0;
        n_res.status = srm_pkg::ST_OK;
        unique case (r_state)
            srm_pkg::S_INIT: begin
                mem_we = 1'b1;
            end
            srm_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                acc_ctrl.start = 1'b1;
                if (in_acc && srm_pkg::t_op'(i_in.operation) == srm_pkg::OP_INSERT) begin
                    res_ld = ins_skip || ins_ovf;
                    n_res.status = ins_skip ? srm_pkg::ST_SKIPPED : srm_pkg::ST_OVERFLOW;
                end
            end
            srm_pkg::S_SCAN: begin
                if (scan_done) begin
                    res_ld = 1'b1;
                    unique case (r_op)
                        srm_pkg::OP_INSERT: begin
                            if (acc_stat.overlap) begin
                                n_res.status = srm_pkg::ST_OVERLAP;
                            end else if (!acc_stat.slot_ok) begin
                                n_res.status = srm_pkg::ST_FULL;
                            end else begin
                                n_res.region_start = r_start;
                                n_res.region_end   = r_end;
                                n_res.found_object = srm_pkg::OBJ_FIELD_W'(r_obj);
                                n_res.found_kind   = r_kind;
                            end
                        end
                        srm_pkg::OP_ADDR: begin
                            if (acc_stat.sel_ok) begin
                                n_res.region_start = acc_stat.sel_start;
                                n_res.region_end   = acc_stat.sel_end;
                                n_res.found_object = srm_pkg::OBJ_FIELD_W'(acc_sel_obj);
                                n_res.found_kind   = acc_stat.sel_kind;
                            end else begin
                                n_res.is_gap       = 1'b1;
                                n_res.region_start = acc_stat.lo;
                                n_res.region_end   = acc_stat.hi;
                            end
                        end
                        srm_pkg::OP_NAME: begin
                            if (acc_stat.sel_ok) begin
                                n_res.region_start = acc_stat.sel_start;
                                n_res.region_end   = acc_stat.sel_end;
                                n_res.found_object = srm_pkg::OBJ_FIELD_W'(acc_sel_obj);
                                n_res.found_kind   = acc_stat.sel_kind;
                            end else begin
                                n_res.status = srm_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_res.status = srm_pkg::ST_OK;
                        end
                    endcase
                end
            end
            srm_pkg::S_WRITE: begin
                // Scan and write never overlap, so no forwarding is needed.
                mem_we    = 1'b1;
                mem_waddr = acc_slot;
                mem_wdata = {1'b1, r_kind, r_obj, r_end, r_start};
            end
            srm_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                res_ld = sweep_last;
            end
            srm_pkg::S_DONE: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srm_pkg::S_INIT;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the sweep or scan pointer; restart it on every new beat.
            if (in_acc) begin
                r_cnt <= '0;
            end else if (r_state == srm_pkg::S_INIT || r_state == srm_pkg::S_CLEAR ||
                         (r_state == srm_pkg::S_SCAN && issue)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_rd_vld <= (r_state == srm_pkg::S_SCAN) && issue;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the item, the pending result and the output beat.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[IDX_W-1:0];
        if (in_acc) begin
            r_op    <= srm_pkg::t_op'(i_in.operation);
            r_obj   <= i_in.object_id[OBJ_W-1:0];
            r_kind  <= i_in.segment_kind;
            r_start <= i_in.seg_start;
            r_end   <= end34[31:0];
            r_addr  <= i_in.query_addr;
        end
        if (res_ld) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    srm_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    srm_acc #(
        .IDX_W (IDX_W),
        .OBJ_W (OBJ_W)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_idx     (r_rd_idx),
        .i_e_valid (e_valid),
        .i_e_start (e_start),
        .i_e_end   (e_end),
        .i_e_obj   (e_obj),
        .i_e_kind  (e_kind),
        .i_q_start (r_start),
        .i_q_end   (r_end),
        .i_q_addr  (r_addr),
        .i_q_obj   (r_obj),
        .i_q_kind  (r_kind),
        .o_stat    (acc_stat),
        .o_slot    (acc_slot),
        .o_sel_obj (acc_sel_obj)
    );

    // A new output beat only ever comes from the result-holding state.
    `SRM_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid),
                    $past(r_state) == srm_pkg::S_DONE,
                    "output beat raised outside result state")
    // A stored insert only follows a clean scan with a free slot.
    `SRM_ASSERT_IMP(a_write_clean, i_clk, i_rst_n, r_state == srm_pkg::S_WRITE,
                    acc_stat.slot_ok && !acc_stat.overlap && r_op == srm_pkg::OP_INSERT,
                    "insert written without free slot or with overlap")
    // An accepted beat always leaves the idle state.
    `SRM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != srm_pkg::S_IDLE,
                    "sequencer stayed idle after accepting a beat")
    // Memory writes never coincide with a scan in flight.
    `SRM_ASSERT_IMP(a_no_write_in_scan, i_clk, i_rst_n, r_rd_vld, !mem_we,
                    "table written while scan data in flight")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_range_map: directed and random table beats,
// each result checked against a shadow copy of the segment table kept here.
// Depends on srm_pkg and the segment_range_map RTL; needs no files at run time.
module tb_top;

    localparam int          TABLE_DEPTH  = srm_pkg::ENTRIES_DEF;
    localparam int          RANDOM_BEATS = 1950;
    localparam int          PHASE_COUNT  = 8;
    localparam int          PHASE_BEATS  = RANDOM_BEATS / PHASE_COUNT;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          STALL_LIMIT  = 3000;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam logic [31:0] GRID_BASE    = 32'h0010_0000;
    localparam int          GRID_STEP    = 'h40;
    localparam int          GRID_SLOTS   = 96;
    localparam logic [31:0] DENSE_BASE   = 32'h0020_0000;
    localparam int          DENSE_SPAN   = 'h1000;
    localparam int          OBJ_POOL     = 8;

    // Shadow of the segment table: predicts one result per accepted input
    // beat and keeps the predictions in arrival order for the output side.
    class segment_table_shadow;
        bit                              used     [TABLE_DEPTH];
        logic [31:0]                     seg_lo   [TABLE_DEPTH];
        logic [31:0]                     seg_hi   [TABLE_DEPTH];
        logic [srm_pkg::OBJ_FIELD_W-1:0] seg_obj  [TABLE_DEPTH];
        logic [1:0]                      seg_kind [TABLE_DEPTH];
        srm_pkg::t_out_item              pending_results [$];
        int                              mismatches;

        function new();
            mismatches = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function srm_pkg::t_out_item apply_insert(srm_pkg::t_in_item beat);
            srm_pkg::t_out_item res;
            logic [63:0]        top;
            int                 slot;
            res  = '0;
            slot = -1;
            if (beat.segment_kind >= srm_pkg::KIND_TOP || beat.seg_start == '0 ||
                beat.seg_size == '0) begin
                res.status = srm_pkg::ST_SKIPPED;
                return res;
            end
            // Round the size up to 16 in 64 bits so a carry out of 32 bits shows.
            top = {32'd0, beat.seg_start} + (({32'd0, beat.seg_size} + 64'd15) & ~64'd15);
            if (top > {32'd0, srm_pkg::ADDR_ALL_ONES}) begin
                res.status = srm_pkg::ST_OVERFLOW;
                return res;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (used[i]) begin
                    if (beat.seg_start < seg_hi[i] && {32'd0, seg_lo[i]} < top) begin
                        res.status = srm_pkg::ST_OVERLAP;
                        return res;
                    end
                end else if (slot < 0) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                res.status = srm_pkg::ST_FULL;
                return res;
            end
            used[slot]     = 1'b1;
            seg_lo[slot]   = beat.seg_start;
            seg_hi[slot]   = top[31:0];
            seg_obj[slot]  = beat.object_id;
            seg_kind[slot] = beat.segment_kind;
            res.status       = srm_pkg::ST_OK;
            res.region_start = beat.seg_start;
            res.region_end   = top[31:0];
            res.found_object = beat.object_id;
            res.found_kind   = beat.segment_kind;
            return res;
        endfunction

        function srm_pkg::t_out_item classify_addr(logic [31:0] addr);
            srm_pkg::t_out_item res;
            logic [31:0]        lo;
            logic [31:0]        hi;
            res = '0;
            lo  = '0;
            hi  = srm_pkg::ADDR_ALL_ONES;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (used[i]) begin
                    if (addr >= seg_lo[i] && addr < seg_hi[i]) begin
                        res.status       = srm_pkg::ST_OK;
                        res.region_start = seg_lo[i];
                        res.region_end   = seg_hi[i];
                        res.found_object = seg_obj[i];
                        res.found_kind   = seg_kind[i];
                        return res;
                    end
                    if (seg_hi[i] <= addr && seg_hi[i] > lo) lo = seg_hi[i];
                    if (seg_lo[i] > addr && seg_lo[i] < hi) hi = seg_lo[i];
                end
            end
            res.status       = srm_pkg::ST_OK;
            res.is_gap       = 1'b1;
            res.region_start = lo;
            res.region_end   = hi;
            return res;
        endfunction

        function srm_pkg::t_out_item find_by_name(srm_pkg::t_in_item beat);
            srm_pkg::t_out_item res;
            int                 best;
            res  = '0;
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (used[i] && seg_obj[i] == beat.object_id &&
                    seg_kind[i] == beat.segment_kind) begin
                    if (best < 0 || seg_lo[i] < seg_lo[best]) best = i;
                end
            end
            if (best < 0) begin
                res.status = srm_pkg::ST_NOT_FOUND;
                return res;
            end
            res.status       = srm_pkg::ST_OK;
            res.region_start = seg_lo[best];
            res.region_end   = seg_hi[best];
            res.found_object = seg_obj[best];
            res.found_kind   = seg_kind[best];
            return res;
        endfunction

        function void note_accepted(srm_pkg::t_in_item beat);
            srm_pkg::t_out_item res;
            res = '0;
            case (beat.operation)
                srm_pkg::OP_INSERT: res = apply_insert(beat);
                srm_pkg::OP_CLEAR: begin
                    foreach (used[i]) used[i] = 1'b0;
                    res.status = srm_pkg::ST_OK;
                end
                srm_pkg::OP_ADDR:   res = classify_addr(beat.query_addr);
                default:            res = find_by_name(beat);
            endcase
            pending_results = {pending_results, res};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(srm_pkg::t_out_item got);
            srm_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction waiting: %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("is_gap", want.is_gap, got.is_gap);
            compare_field("region_start", want.region_start, got.region_start);
            compare_field("region_end", want.region_end, got.region_end);
            compare_field("found_object", want.found_object, got.found_object);
            compare_field("found_kind", want.found_kind, got.found_kind);
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    srm_pkg::t_in_item  i_in        = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    srm_pkg::t_out_item o_out;

    segment_table_shadow shadow;

    // Idle controls, set per phase by the stimulus process, and the quiet-cycle count.
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    bit hold_off_req  = 1'b0;
    int quiet_cycles  = 0;

    // Random stimulus state: grid epochs fill the table slot by slot so it
    // runs full; dense epochs pack short segments into a small window so
    // that overlaps and adjacent ends are common.
    bit grid_style = 1'b0;
    int grid_next  = 0;

    segment_range_map DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: stall at random, and once hold ready low for a long
    // stretch so the block backs up and stops taking input beats.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) < out_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // Check every result beat at the edge that accepts it; count cycles
    // with no beat moving either way and give up past the limit.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_result(o_out);
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one beat from the falling edge, idling first if the phase says
    // so; hold it until accepted, then note it in the shadow.
    task automatic send_beat(input srm_pkg::t_in_item beat);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in       <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_accepted(beat);
    endtask

    function automatic srm_pkg::t_in_item make_beat(srm_pkg::t_op op,
                                                    logic [srm_pkg::OBJ_FIELD_W-1:0] obj,
                                                    logic [1:0] kind, logic [31:0] start,
                                                    logic [31:0] size, logic [31:0] addr);
        srm_pkg::t_in_item beat;
        beat.operation    = op;
        beat.object_id    = obj;
        beat.segment_kind = kind;
        beat.seg_start    = start;
        beat.seg_size     = size;
        beat.query_addr   = addr;
        return beat;
    endfunction

    // Mostly a small pool of ids so that name lookups find several matches.
    function automatic logic [srm_pkg::OBJ_FIELD_W-1:0] pick_object();
        if ($urandom_range(0, 9) == 0)
            return srm_pkg::OBJ_FIELD_W'($urandom);
        return srm_pkg::OBJ_FIELD_W'($urandom_range(0, OBJ_POOL - 1));
    endfunction

    // Index of a random stored segment, or -1 when the table is empty.
    function automatic int pick_stored();
        int idx [$];
        foreach (shadow.used[i])
            if (shadow.used[i]) idx = {idx, i};
        if (idx.size() == 0)
            return -1;
        return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    function automatic srm_pkg::t_in_item random_beat();
        srm_pkg::t_in_item beat;
        int                pick;
        int                slot;
        logic [31:0]       lo;
        logic [31:0]       hi;
        // Start from all fields random so unused fields toggle too.
        beat = make_beat(srm_pkg::t_op'($urandom_range(0, 3)),
                         srm_pkg::OBJ_FIELD_W'($urandom),
                         2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return beat;
        if (pick < 62) begin
            beat.operation    = srm_pkg::OP_INSERT;
            beat.object_id    = pick_object();
            if ($urandom_range(0, 9) == 0)
                beat.segment_kind = $urandom_range(0, 1) ? KIND_UNUSED : srm_pkg::KIND_TOP;
            else
                beat.segment_kind = $urandom_range(0, 1) ? srm_pkg::KIND_DEBUG :
                                                           srm_pkg::KIND_MAIN;
            if (grid_style) begin
                if ($urandom_range(0, 4) != 0) begin
                    slot      = grid_next;
                    grid_next = (grid_next + 1) % GRID_SLOTS;
                end else begin
                    slot = $urandom_range(0, GRID_SLOTS - 1);
                end
                beat.seg_start = GRID_BASE + slot * GRID_STEP;
                // Now and then spill into the next grid slot.
                if ($urandom_range(0, 7) == 0)
                    beat.seg_size = $urandom_range(GRID_STEP + 1, 2 * GRID_STEP);
                else
                    beat.seg_size = $urandom_range(1, GRID_STEP);
            end else begin
                beat.seg_start = DENSE_BASE + $urandom_range(0, DENSE_SPAN);
                beat.seg_size  = $urandom_range(1, 256);
            end
            case ($urandom_range(0, 39))
                0: beat.seg_start = '0;
                1: beat.seg_size  = '0;
                2: beat.seg_start = srm_pkg::ADDR_ALL_ONES - $urandom_range(0, 96);
                default: ;
            endcase
            return beat;
        end
        slot = pick_stored();
        if (pick < 82) begin
            beat.operation = srm_pkg::OP_ADDR;
            pick = $urandom_range(0, 9);
            if (pick >= 2 && pick < 5) begin
                lo = grid_style ? GRID_BASE : DENSE_BASE;
                beat.query_addr = lo - 64 + $urandom_range(0, 'h1800);
            end else if (pick >= 5 && slot >= 0) begin
                lo = shadow.seg_lo[slot];
                hi = shadow.seg_hi[slot];
                case ($urandom_range(0, 4))
                    0: beat.query_addr = lo;
                    1: beat.query_addr = hi - 1;
                    2: beat.query_addr = hi;
                    3: beat.query_addr = lo - 1;
                    default: beat.query_addr = lo + $urandom_range(0, hi - lo - 1);
                endcase
            end
            return beat;
        end
        beat.operation = srm_pkg::OP_NAME;
        if (slot >= 0 && $urandom_range(0, 2) != 0) begin
            beat.object_id    = shadow.seg_obj[slot];
            beat.segment_kind = shadow.seg_kind[slot];
        end else begin
            beat.object_id    = pick_object();
            beat.segment_kind = 2'($urandom_range(0, 3));
        end
        return beat;
    endfunction

    initial begin
        int epoch_left;
        int mode;
        shadow = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, skips, overflow, adjacency, overlap, hits, gaps.
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0, '0));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0,
                            srm_pkg::ADDR_ALL_ONES));
        send_beat(make_beat(srm_pkg::OP_NAME, 16'h0001, srm_pkg::KIND_MAIN, '0, '0, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, srm_pkg::KIND_TOP,
                            32'h1000, 32'h10, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, KIND_UNUSED,
                            32'h1000, 32'h10, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, srm_pkg::KIND_MAIN,
                            '0, 32'h10, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, srm_pkg::KIND_MAIN,
                            32'h1000, '0, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, srm_pkg::KIND_MAIN,
                            32'hFFFF_FFF0, 32'h10, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, srm_pkg::KIND_DEBUG,
                            32'h1, srm_pkg::ADDR_ALL_ONES, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'hFFFF, srm_pkg::KIND_DEBUG,
                            32'hFFFF_FFE0, 32'h1, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0000, srm_pkg::KIND_MAIN,
                            32'h1000, 32'h20, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0001, srm_pkg::KIND_MAIN,
                            32'h101F, 32'h1, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0000, srm_pkg::KIND_MAIN,
                            32'h1020, 32'h11, '0));
        send_beat(make_beat(srm_pkg::OP_INSERT, 16'h0002, srm_pkg::KIND_DEBUG,
                            32'h0FFF, 32'h1, '0));
        send_beat(make_beat(srm_pkg::OP_NAME, 16'h0000, srm_pkg::KIND_MAIN, '0, '0, '0));
        send_beat(make_beat(srm_pkg::OP_NAME, 16'h0000, srm_pkg::KIND_DEBUG, '0, '0, '0));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0, 32'h1000));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0, 32'h103F));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0, 32'h1040));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0, 32'h0FFF));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0,
                            srm_pkg::ADDR_ALL_ONES));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0,
                            32'hFFFF_FFEF));
        send_beat(make_beat(srm_pkg::OP_NAME, 16'hFFFF, srm_pkg::KIND_DEBUG, '0, '0, '0));
        send_beat(make_beat(srm_pkg::OP_CLEAR, '0, srm_pkg::KIND_MAIN, '0, '0, '0));
        send_beat(make_beat(srm_pkg::OP_ADDR, '0, srm_pkg::KIND_MAIN, '0, '0, 32'h1000));

        // Random: epochs open with a clear; idling modes rotate per phase
        // (none, sender, receiver, both), the first phase with the long hold-off.
        epoch_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % PHASE_BEATS == 0) begin
                mode          = (n / PHASE_BEATS) % 4;
                send_idle_pct = (mode == 1) ? 70 : (mode == 3) ? 10 : 0;
                out_stall_pct = (mode == 2) ? 70 : (mode == 3) ? 10 : 0;
                if (n == 0)
                    hold_off_req = 1'b1;
            end
            if (epoch_left == 0) begin
                grid_style = $urandom_range(0, 1);
                grid_next  = 0;
                epoch_left = $urandom_range(100, 220);
                send_beat(make_beat(srm_pkg::OP_CLEAR, srm_pkg::OBJ_FIELD_W'($urandom),
                                    2'($urandom_range(0, 3)),
                                    $urandom, $urandom, $urandom));
            end else begin
                send_beat(random_beat());
                epoch_left--;
            end
        end

        // Drain: drop valid, wait for every predicted result, then let the
        // block's scan length pass to catch any stray beat.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (shadow.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
